>>> sv/sacl_pkg.sv
// Shared types and constants for the set-associative cache lookup block.
// No dependencies; imported by the top level and the way matcher.
package sacl_pkg;

	// Fixed field widths
	localparam int ADDR_W      = 48;
	localparam int CFG_IDX_W   = 8;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 152;

	// Default geometry
	localparam int DEF_SET_COUNT   = 64;
	localparam int DEF_WAYS        = 4;
	localparam int DEF_BLOCK_BYTES = 64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REGION_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_HIGH = 8'd1;

	// Access kind
	localparam logic CMD_WRITE = 1'b1;

	// Per-way status code
	typedef enum logic [1:0] {
		ST_INVALID = 2'd0,
		ST_VALID   = 2'd1,
		ST_DIRTY   = 2'd2
	} way_status_t;

	// Controller states
	typedef enum logic [1:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_LOOKUP
	} ctrl_state_t;

	// Lookup outcome flags from the way matcher
	typedef struct packed {
		logic hit;
		logic wb_valid;
		logic fill_valid;
	} lookup_flags_t;

endpackage

>>> sv/set_assoc_cache_lookup_rr_top.sv
// Top level of the set-associative write-back cache lookup (round-robin replacement).
// Depends on sacl_pkg, sacl_ram and sacl_match.
//
// Usage: an address (s_tdata) and command (s_tuser, 1 = write) are taken on the
// slave stream. Each transfer yields one result on the master stream: bypass flag
// in m_tuser, translated offset, hit, writeback and fill requests in m_tdata.
// Addresses outside [region_low, region_high) come back unchanged with bypass set.
// The region registers are to be written over the cfg channel only while the block is
// idle; the block itself does not enforce this. Results pass through the registered
// row read and the output register. A row is read when its item is accepted and written
// back when the result moves on; s_tready is low until then, so no new item is taken.
// Reset: after arst_n releases, a clearing pass writes every set row to zero
// (tags 0, ways invalid, pointer 0); it covers SET_COUNT rounded up to a power of
// two rows, during which s_tready is low. Config writes are taken at any time.
// Stall: the result sits in an output register; a held m_tready keeps the next
// item in the lookup cycle, with its row update deferred until the result moves.
module set_assoc_cache_lookup_rr_top #(
	parameter int SET_COUNT   = sacl_pkg::DEF_SET_COUNT,
	parameter int WAYS        = sacl_pkg::DEF_WAYS,
	parameter int BLOCK_BYTES = sacl_pkg::DEF_BLOCK_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sacl_pkg::ADDR_W-1:0]      cfg_data,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sacl_pkg::S_TDATA_W-1:0]   s_tdata,  // [47:0] address
	input  logic                             s_tuser,  // [0] command
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [47:0] out_address, [48] hit, [49] writeback_valid, [97:50] writeback_address,
	// [98] fill_valid, [146:99] fill_address, [151:147] zero
	output logic [sacl_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                             m_tuser   // [0] bypass
);
	import sacl_pkg::*;

	localparam int IDX_W   = $clog2(SET_COUNT);
	localparam int WAY_W   = $clog2(WAYS);
	localparam int OFF_W   = $clog2(BLOCK_BYTES);
	localparam int SETS_P2 = 1 << IDX_W;
	localparam int WAYS_P2 = 1 << WAY_W;
	localparam int SET_W   = (IDX_W > 0) ? IDX_W : 1;
	localparam int PTR_W   = (WAY_W > 0) ? WAY_W : 1;
	localparam int TAG_W   = ADDR_W - IDX_W - OFF_W;
	localparam int ROW_W   = PTR_W + WAYS_P2 * (2 + TAG_W);
	localparam logic [ADDR_W-1:0] OFF_MASK = (ADDR_W'(1) << OFF_W) - 1'b1;
	localparam logic [ADDR_W-1:0] SET_MASK = (ADDR_W'(1) << IDX_W) - 1'b1;
	localparam logic [SET_W-1:0]  LAST_SET = SET_W'(SETS_P2 - 1);

	ctrl_state_t state_q, state_d;

	logic [ADDR_W-1:0] region_low_q, region_high_q;
	logic [SET_W-1:0]  clr_idx_q;
	logic [ADDR_W-1:0] addr_q;
	logic              write_q;
	logic              bypass_q;
	logic              m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;
	logic              m_user_q;

	logic              accept, finish, out_free;
	logic              in_bypass;
	logic [ADDR_W-1:0] in_addr;
	logic [SET_W-1:0]  in_set;

	logic              ram_we, ram_re;
	logic [SET_W-1:0]  ram_waddr;
	logic [ROW_W-1:0]  ram_wdata, ram_rdata;

	logic [ADDR_W-1:0] set48;
	logic [SET_W-1:0]  cur_set;
	logic [TAG_W-1:0]  cur_tag;

	logic [WAYS_P2-1:0][TAG_W-1:0] row_tags, new_tags;
	logic [WAYS_P2-1:0][1:0]       row_status, new_status;
	logic [PTR_W-1:0]              row_ptr, new_ptr, way;
	logic [TAG_W-1:0]              victim_tag;
	lookup_flags_t                 flags;

	logic [ADDR_W-1:0] res_out_addr, res_wb_addr, res_fill_addr;
	logic [M_TDATA_W-1:0] res_data;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_low_q  <= '0;
			region_high_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REGION_LOW:  region_low_q  <= cfg_data;
				REG_REGION_HIGH: region_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode
	assign in_addr   = s_tdata[ADDR_W-1:0];
	assign in_bypass = (in_addr < region_low_q) || (in_addr >= region_high_q);
	assign in_set    = SET_W'((in_addr >> OFF_W) & SET_MASK);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_CLEAR:  if (clr_idx_q == LAST_SET) state_d = CS_IDLE;
			CS_IDLE:   if (s_tvalid) state_d = CS_LOOKUP;
			CS_LOOKUP: if (out_free) state_d = CS_IDLE;
			default:   state_d = CS_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready  = 1'b0;
		finish    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cur_set;
		ram_wdata = {new_ptr, new_status, new_tags};
		case (state_q)
			CS_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
			end
			CS_IDLE: begin
				s_tready = 1'b1;
			end
			CS_LOOKUP: begin
				finish = out_free;
				ram_we = out_free && !bypass_q;
			end
			default: ;
		endcase
	end
	assign ram_re = accept;

	// state, clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CS_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == CS_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= in_addr;
			write_q  <= s_tuser;
			bypass_q <= in_bypass;
		end
	end

	sacl_ram #(
		.DEPTH  (SETS_P2),
		.AW     (SET_W),
		.DATA_W (ROW_W)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (in_set),
		.rdata (ram_rdata)
	);

	// row unpack and address split of the item under lookup
	assign row_ptr    = ram_rdata[ROW_W-1 -: PTR_W];
	assign row_status = ram_rdata[WAYS_P2*TAG_W +: WAYS_P2*2];
	assign row_tags   = ram_rdata[WAYS_P2*TAG_W-1:0];
	assign set48      = (addr_q >> OFF_W) & SET_MASK;
	assign cur_set    = SET_W'(set48);
	assign cur_tag    = TAG_W'(addr_q >> (OFF_W + IDX_W));

	sacl_match #(
		.WAYS_P2 (WAYS_P2),
		.WAY_W   (WAY_W),
		.PTR_W   (PTR_W),
		.TAG_W   (TAG_W)
	) u_match (
		.row_tags   (row_tags),
		.row_status (row_status),
		.row_ptr    (row_ptr),
		.tag        (cur_tag),
		.is_write   (write_q),
		.way        (way),
		.flags      (flags),
		.victim_tag (victim_tag),
		.new_tags   (new_tags),
		.new_status (new_status),
		.new_ptr    (new_ptr)
	);

	// result fields; the address pieces occupy disjoint bit ranges
	assign res_out_addr  = (set48 << (WAY_W + OFF_W)) | (ADDR_W'(way) << OFF_W)
		| (addr_q & OFF_MASK);
	assign res_wb_addr   = flags.wb_valid ?
		((ADDR_W'(victim_tag) << (IDX_W + OFF_W)) | (set48 << OFF_W)) : '0;
	assign res_fill_addr = flags.fill_valid ? (addr_q & ~OFF_MASK) : '0;

	always_comb begin
		res_data = '0;
		if (bypass_q) begin
			res_data[ADDR_W-1:0] = addr_q;
		end else begin
			res_data[47:0]   = res_out_addr;
			res_data[48]     = flags.hit;
			res_data[49]     = flags.wb_valid;
			res_data[97:50]  = res_wb_addr;
			res_data[98]     = flags.fill_valid;
			res_data[146:99] = res_fill_addr;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_data_q <= res_data;
			m_user_q <= bypass_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

>>> sv/sacl_ram.sv
// Single-port-write, single-port-read synchronous RAM holding one set row per entry.
// Read data registered. Depends on nothing.
module sacl_ram #(
	parameter int DEPTH  = 64,
	parameter int AW     = 6,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/sacl_match.sv
// Way matcher: compares the tags of one set row in parallel, picks the hit or
// round-robin victim way and builds the updated row. Depends on sacl_pkg.
module sacl_match #(
	parameter int WAYS_P2 = 4,
	parameter int WAY_W   = 2,
	parameter int PTR_W   = 2,
	parameter int TAG_W   = 36
) (
	input  logic [WAYS_P2-1:0][TAG_W-1:0] row_tags,
	input  logic [WAYS_P2-1:0][1:0]       row_status,
	input  logic [PTR_W-1:0]              row_ptr,
	input  logic [TAG_W-1:0]              tag,
	input  logic                          is_write,
	output logic [PTR_W-1:0]              way,
	output sacl_pkg::lookup_flags_t       flags,
	output logic [TAG_W-1:0]              victim_tag,
	output logic [WAYS_P2-1:0][TAG_W-1:0] new_tags,
	output logic [WAYS_P2-1:0][1:0]       new_status,
	output logic [PTR_W-1:0]              new_ptr
);
	import sacl_pkg::*;

	logic [WAYS_P2-1:0] match;
	logic               hit;
	logic [PTR_W-1:0]   hit_way;

	// parallel tag compare against valid ways
	always_comb begin
		for (int w = 0; w < WAYS_P2; w++) begin
			match[w] = (row_status[w] != ST_INVALID) && (row_tags[w] == tag);
		end
	end

	// lowest matching way wins
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAYS_P2 - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit     = 1'b1;
				hit_way = PTR_W'(w);
			end
		end
	end

	assign way              = hit ? hit_way : row_ptr;
	assign victim_tag       = row_tags[row_ptr];
	assign flags.hit        = hit;
	assign flags.fill_valid = !hit;
	assign flags.wb_valid   = !hit && (row_status[row_ptr] == ST_DIRTY);

	// updated row: new tag on a miss, status per access kind, pointer advance
	always_comb begin
		new_tags   = row_tags;
		new_status = row_status;
		if (!hit) begin
			new_tags[row_ptr] = tag;
		end
		if (is_write == CMD_WRITE) begin
			new_status[way] = ST_DIRTY;
		end else if (!hit) begin
			new_status[way] = ST_VALID;
		end
		if (hit || WAY_W == 0) begin
			new_ptr = hit ? row_ptr : '0;
		end else begin
			new_ptr = row_ptr + 1'b1;
		end
	end

endmodule
